// ===== sv/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants for the bilinear image scaler
// Frame store geometry, fixed-point widths, register indexes and the
// command word passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_WIDTH     = 256;
  localparam int MAX_HEIGHT    = 256;
  localparam int FRACTION_BITS = 16;

  localparam int PIX_W    = 8;
  localparam int SRC_W    = 8;
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 9;
  localparam int SCALE_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int IDX_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int POS_W   = COORD_W + SCALE_W;
  localparam int WHOLE_W = POS_W - FRACTION_BITS;
  localparam int BLEND_W = PIX_W + FRACTION_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE = 2'd2;

  localparam logic [DIM_W-1:0]   RESET_SOURCE_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0]   RESET_SOURCE_HEIGHT = 9'd256;
  localparam logic [SCALE_W-1:0] RESET_INVERSE_SCALE = 24'd32768;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_ROW,
    ST_MAP_COL,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_RD_D,
    ST_LERP_TOP,
    ST_LERP_BOT,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_QUERY,
    OP_MAP_ROW,
    OP_MAP_COL,
    OP_RD_A,
    OP_RD_B,
    OP_RD_C,
    OP_RD_D,
    OP_LERP_TOP,
    OP_LERP_BOT,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

endpackage

// ===== sv/bis_ctrl.sv =====
// ----------------------------------------------------------------------------
// bis_ctrl: sequencer for the bilinear image scaler
// Takes input words, steps a query through mapping, four store reads and
// three blend steps, and owns the output valid flag.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          kind,
  output logic          out_valid,
  input  logic          out_ready,
  output bis_pkg::cmd_t cmd
);
  import bis_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && kind == KIND_QUERY) state_next = ST_MAP_ROW;
      end
      ST_MAP_ROW:  state_next = ST_MAP_COL;
      ST_MAP_COL:  state_next = ST_RD_A;
      ST_RD_A:     state_next = ST_RD_B;
      ST_RD_B:     state_next = ST_RD_C;
      ST_RD_C:     state_next = ST_RD_D;
      ST_RD_D:     state_next = ST_LERP_TOP;
      ST_LERP_TOP: state_next = ST_LERP_BOT;
      ST_LERP_BOT: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) cmd.op = (kind == KIND_QUERY) ? OP_QUERY : OP_LOAD;
      end
      ST_MAP_ROW:  cmd.op = OP_MAP_ROW;
      ST_MAP_COL:  cmd.op = OP_MAP_COL;
      ST_RD_A:     cmd.op = OP_RD_A;
      ST_RD_B:     cmd.op = OP_RD_B;
      ST_RD_C:     cmd.op = OP_RD_C;
      ST_RD_D:     cmd.op = OP_RD_D;
      ST_LERP_TOP: cmd.op = OP_LERP_TOP;
      ST_LERP_BOT: cmd.op = OP_LERP_BOT;
      ST_OUT: begin
        if (out_free) cmd.op = OP_OUT;
      end
      default:     cmd.op = OP_NONE;
    endcase
  end

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_QUERY) |=> (state == ST_MAP_ROW))
    else $error("query accepted but mapping did not start");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_LOAD) |=> (state == ST_IDLE))
    else $error("load word left the idle state");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("finished result not posted");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_free) |=> (state == ST_OUT))
    else $error("result step left while output register full");

endmodule

// ===== sv/bis_datapath.sv =====
// ----------------------------------------------------------------------------
// bis_datapath: frame store, coordinate mapping and blend unit
// Holds the configuration registers, the single-port-read frame store, a
// shared coordinate multiplier and a shared linear blend unit.
// ----------------------------------------------------------------------------
module bis_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  bis_pkg::cmd_t                      cmd,
  input  logic                               cfg_valid,
  input  logic [bis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [bis_pkg::SRC_W-1:0]          src_row,
  input  logic [bis_pkg::SRC_W-1:0]          src_col,
  input  logic [bis_pkg::PIX_W-1:0]          pixel_in,
  input  logic [bis_pkg::COORD_W-1:0]        out_row,
  input  logic [bis_pkg::COORD_W-1:0]        out_col,
  output logic [bis_pkg::PIX_W-1:0]          pixel_out,
  output logic                               range_error
);
  import bis_pkg::*;

  logic [DIM_W-1:0]   source_width;
  logic [DIM_W-1:0]   source_height;
  logic [SCALE_W-1:0] inverse_scale;

  logic [PIX_W-1:0] mem [0:DEPTH-1];
  logic [PIX_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic              wr_en;

  logic [COORD_W-1:0]       q_row;
  logic [COORD_W-1:0]       q_col;
  logic [ROW_W-1:0]         y1;
  logic [ROW_W-1:0]         y2;
  logic [COL_W-1:0]         x1;
  logic [COL_W-1:0]         x2;
  logic [FRACTION_BITS-1:0] fx;
  logic [FRACTION_BITS-1:0] fy;
  logic                     err;
  logic [PIX_W-1:0]         pa;
  logic [PIX_W-1:0]         pb;
  logic [PIX_W-1:0]         pc;
  logic [PIX_W-1:0]         pd;
  logic [BLEND_W-1:0]       top;
  logic [BLEND_W-1:0]       bot;

  logic [IDX_W-1:0]         last_col;
  logic [IDX_W-1:0]         last_row;
  logic [COORD_W-1:0]       m_coord;
  logic [IDX_W-1:0]         m_last;
  logic [POS_W-1:0]         pos;
  logic [WHOLE_W-1:0]       whole;
  logic                     clamp;
  logic [IDX_W-1:0]         near_idx;
  logic [IDX_W-1:0]         far_idx;
  logic [FRACTION_BITS-1:0] m_frac;

  logic [BLEND_W-1:0]                  la;
  logic [BLEND_W-1:0]                  lb;
  logic [FRACTION_BITS-1:0]            lf;
  logic signed [BLEND_W:0]             diff;
  logic signed [BLEND_W+FRACTION_BITS+1:0] prod;
  logic [BLEND_W+FRACTION_BITS+1:0]    sum;
  logic [BLEND_W+FRACTION_BITS-1:0]    lerp_res;

  function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] v,
                                                  input int maxv);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > maxv) begin
      r = IDX_W'(maxv - 1);
    end else begin
      r = IDX_W'(v - 1'b1);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c));
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RESET_SOURCE_WIDTH;
      source_height <= RESET_SOURCE_HEIGHT;
      inverse_scale <= RESET_INVERSE_SCALE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[DIM_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[DIM_W-1:0];
        REG_INVERSE_SCALE: inverse_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign last_col = last_index(source_width, MAX_WIDTH);
  assign last_row = last_index(source_height, MAX_HEIGHT);

  // frame store
  assign wr_en = (cmd.op == OP_LOAD) && (32'(src_row) < MAX_HEIGHT)
                 && (32'(src_col) < MAX_WIDTH);
  assign waddr = pix_addr(ROW_W'(src_row), COL_W'(src_col));

  always_comb begin
    case (cmd.op)
      OP_RD_B: raddr = pix_addr(y1, x2);
      OP_RD_C: raddr = pix_addr(y2, x1);
      OP_RD_D: raddr = pix_addr(y2, x2);
      default: raddr = pix_addr(y1, x1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= pixel_in;
    end
    rdata <= mem[raddr];
  end

  // coordinate mapping, one axis per cycle
  assign m_coord  = (cmd.op == OP_MAP_ROW) ? q_row : q_col;
  assign m_last   = (cmd.op == OP_MAP_ROW) ? last_row : last_col;
  assign pos      = POS_W'(m_coord) * POS_W'(inverse_scale);
  assign whole    = pos[POS_W-1:FRACTION_BITS];
  assign clamp    = whole > WHOLE_W'(m_last);
  assign near_idx = clamp ? m_last : whole[IDX_W-1:0];
  assign far_idx  = (near_idx == m_last) ? near_idx : IDX_W'(near_idx + 1'b1);
  assign m_frac   = clamp ? '0 : pos[FRACTION_BITS-1:0];

  // blend: a + (b - a) * f, scaled by 2^F
  always_comb begin
    case (cmd.op)
      OP_LERP_TOP: begin
        la = BLEND_W'(pa);
        lb = BLEND_W'(pb);
        lf = fx;
      end
      OP_LERP_BOT: begin
        la = BLEND_W'(pc);
        lb = BLEND_W'(pd);
        lf = fx;
      end
      default: begin
        la = top;
        lb = bot;
        lf = fy;
      end
    endcase
  end

  assign diff     = $signed({1'b0, lb}) - $signed({1'b0, la});
  assign prod     = diff * $signed({1'b0, lf});
  assign sum      = {2'b00, la, {FRACTION_BITS{1'b0}}} + $unsigned(prod);
  assign lerp_res = sum[BLEND_W+FRACTION_BITS-1:0];

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_QUERY: begin
        q_row <= out_row;
        q_col <= out_col;
      end
      OP_MAP_ROW: begin
        y1  <= near_idx[ROW_W-1:0];
        y2  <= far_idx[ROW_W-1:0];
        fy  <= m_frac;
        err <= clamp;
      end
      OP_MAP_COL: begin
        x1  <= near_idx[COL_W-1:0];
        x2  <= far_idx[COL_W-1:0];
        fx  <= m_frac;
        err <= err | clamp;
      end
      OP_RD_B: pa <= rdata;
      OP_RD_C: pb <= rdata;
      OP_RD_D: pc <= rdata;
      OP_LERP_TOP: begin
        pd  <= rdata;
        top <= lerp_res[BLEND_W-1:0];
      end
      OP_LERP_BOT: bot <= lerp_res[BLEND_W-1:0];
      OP_OUT: begin
        pixel_out   <= lerp_res[BLEND_W+FRACTION_BITS-1:2*FRACTION_BITS];
        range_error <= err;
      end
      default: ;
    endcase
  end

  a_col_neighbors: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_MAP_COL) |=>
      (IDX_W'(x1) <= last_col && (x2 == x1 || x2 == COL_W'(x1 + 1'b1))))
    else $error("column neighbors out of order or past last column");

  a_row_neighbors: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_MAP_ROW) |=>
      (IDX_W'(y1) <= last_row && (y2 == y1 || y2 == ROW_W'(y1 + 1'b1))))
    else $error("row neighbors out of order or past last row");

  a_clamp_weight: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_MAP_ROW && clamp) |=> (fy == '0 && err))
    else $error("clamped row kept a nonzero weight");

endmodule

// ===== sv/bilinear_image_scaler_top.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_scaler_top: grayscale bilinear scaler with frame store
// Load words fill the frame store; query words return one blended pixel.
// ----------------------------------------------------------------------------
// A load word is taken while idle and the next word may follow at once.
// After a query word is accepted, no word is taken until it has been through
// two steps on the shared coordinate multiplier (row, then column),
// four frame store reads through its single read port, and three
// steps on the shared blend unit, the last of which fills the output
// register. The result appears in the cycle after that step and may wait
// there while the block takes further load or query words; a later query
// holds in its final step until the waiting result has been taken.
// Configuration writes are always accepted and must only be issued while
// no query is in flight. Reading a store location never loaded returns
// an undefined pixel.
module bilinear_image_scaler_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic [bis_pkg::SRC_W-1:0]          src_row,
  input  logic [bis_pkg::SRC_W-1:0]          src_col,
  input  logic [bis_pkg::PIX_W-1:0]          pixel_in,
  input  logic [bis_pkg::COORD_W-1:0]        out_row,
  input  logic [bis_pkg::COORD_W-1:0]        out_col,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bis_pkg::PIX_W-1:0]          pixel_out,
  output logic                               range_error,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bis_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bis_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .src_row     (src_row),
    .src_col     (src_col),
    .pixel_in    (pixel_in),
    .out_row     (out_row),
    .out_col     (out_col),
    .pixel_out   (pixel_out),
    .range_error (range_error)
  );

endmodule

// ===== verif/bilinear_scaler_checker.sv =====
// ----------------------------------------------------------------------------
// bilinear_scaler_checker: result prediction for the bilinear image scaler
// Watches the load/query, result and register channels, keeps its own copy
// of the frame store and registers, computes each blended pixel and its
// clamp flag, and compares every result word in order.
// ----------------------------------------------------------------------------
module bilinear_scaler_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           kind,
  input  logic [bis_pkg::SRC_W-1:0]      src_row,
  input  logic [bis_pkg::SRC_W-1:0]      src_col,
  input  logic [bis_pkg::PIX_W-1:0]      pixel_in,
  input  logic [bis_pkg::COORD_W-1:0]    out_row,
  input  logic [bis_pkg::COORD_W-1:0]    out_col,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [bis_pkg::PIX_W-1:0]      pixel_out,
  input  logic                           range_error,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  import bis_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             clamped;
  } scaled_px_t;

  typedef struct packed {
    logic [IDX_W-1:0]         lo;
    logic [IDX_W-1:0]         hi;
    logic [FRACTION_BITS-1:0] frac;
    logic                     clamped;
  } axis_map_t;

  logic [PIX_W-1:0]   frame_copy [DEPTH];
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [SCALE_W-1:0] scale_reg;
  scaled_px_t         pending_pixels [$];

  function automatic int unsigned usable_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic axis_map_t map_axis(logic [COORD_W-1:0] c, int unsigned dim);
    axis_map_t          m;
    logic [POS_W-1:0]   pos;
    logic [WHOLE_W-1:0] whole;
    pos = POS_W'(c) * POS_W'(scale_reg);
    whole = pos[POS_W-1:FRACTION_BITS];
    m.frac = pos[FRACTION_BITS-1:0];
    m.clamped = (whole > dim - 1);
    if (m.clamped) begin
      whole = WHOLE_W'(dim - 1);
      m.frac = '0;
    end
    m.lo = IDX_W'(whole);
    m.hi = (whole + 1 < dim) ? IDX_W'(whole + 1) : IDX_W'(dim - 1);
    return m;
  endfunction

  function automatic longint unsigned texel(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    return frame_copy[row * MAX_WIDTH + col];
  endfunction

  function automatic scaled_px_t blend_pixel(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
    scaled_px_t        px;
    axis_map_t         ry;
    axis_map_t         cx;
    longint unsigned   one;
    longint unsigned   wx;
    longint unsigned   wy;
    longint unsigned   top_sum;
    longint unsigned   bot_sum;
    ry = map_axis(r, usable_dim(height_reg, MAX_HEIGHT));
    cx = map_axis(c, usable_dim(width_reg, MAX_WIDTH));
    one = 64'd1 << FRACTION_BITS;
    wx = cx.frac;
    wy = ry.frac;
    top_sum = texel(ry.lo, cx.lo) * (one - wx) + texel(ry.lo, cx.hi) * wx;
    bot_sum = texel(ry.hi, cx.lo) * (one - wx) + texel(ry.hi, cx.hi) * wx;
    px.value = PIX_W'((top_sum * (one - wy) + bot_sum * wy) >> (2 * FRACTION_BITS));
    px.clamped = ry.clamped | cx.clamped;
    return px;
  endfunction

  always @(posedge clk) begin
    scaled_px_t want;
    if (rst) begin
      width_reg = RESET_SOURCE_WIDTH;
      height_reg = RESET_SOURCE_HEIGHT;
      scale_reg = RESET_INVERSE_SCALE;
      pending_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          mismatches++;
          $error("unexpected result word: pixel_out %0d range_error %0d",
                 pixel_out, range_error);
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_out !== want.value) begin
            mismatches++;
            $error("pixel_out: expected %0d, got %0d", want.value, pixel_out);
          end
          if (range_error !== want.clamped) begin
            mismatches++;
            $error("range_error: expected %0d, got %0d", want.clamped, range_error);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOURCE_WIDTH:  width_reg = cfg_data[DIM_W-1:0];
          REG_SOURCE_HEIGHT: height_reg = cfg_data[DIM_W-1:0];
          REG_INVERSE_SCALE: scale_reg = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (kind == KIND_LOAD) begin
          frame_copy[src_row * MAX_WIDTH + src_col] = pixel_in;
        end else begin
          pending_pixels.push_back(blend_pixel(out_row, out_col));
        end
      end
    end
    outstanding = pending_pixels.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: bilinear image scaler
// Fills the frame store with load words and issues query words under a
// series of register settings (unit, minimum, maximum, zero and random
// scales and sizes), with random idling on both channels and one long
// result stall; every result is checked by the companion checker.
// ----------------------------------------------------------------------------
module testbench;
  import bis_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WORD_TARGET   = 600;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 12;

  typedef enum int {PACE_FULL, PACE_RANDOM, PACE_BURSTY} pace_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  kind;
  logic [SRC_W-1:0]      src_row;
  logic [SRC_W-1:0]      src_col;
  logic [PIX_W-1:0]      pixel_in;
  logic [COORD_W-1:0]    out_row;
  logic [COORD_W-1:0]    out_col;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIX_W-1:0]      pixel_out;
  logic                  range_error;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;

  pace_t       feed_pace;
  pace_t       drain_pace;
  bit          drain_hold;
  bit          loaded [DEPTH];
  int unsigned eff_width;
  int unsigned eff_height;
  int unsigned eff_scale;
  int          words_sent;
  int          queries_sent;
  int          results_taken;
  int          clamped_seen;
  int          settings_used;

  bilinear_image_scaler_top dut (.*);

  bilinear_scaler_checker pixel_check (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int draw_gap(pace_t p);
    case (p)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, 16);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  function automatic int unsigned dim_in_use(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned axis_start(logic [COORD_W-1:0] c, int unsigned dim);
    longint unsigned whole;
    whole = (64'(c) * eff_scale) >> FRACTION_BITS;
    return (whole > dim - 1) ? dim - 1 : 32'(whole);
  endfunction

  // mostly lands inside the image, sometimes anywhere in the coordinate range
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned dim);
    longint unsigned reach;
    if ($urandom_range(0, 4) == 0) return COORD_W'($urandom);
    reach = (eff_scale == 0) ? 4095 : ((64'(dim) << FRACTION_BITS) / eff_scale);
    if (reach > 4095) reach = 4095;
    return COORD_W'($urandom_range(0, 32'(reach)));
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511);
      1, 2, 3: return $urandom_range(1, 4);
      4, 5:    return $urandom_range(200, 256);
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  task automatic send_word(input logic k, input logic [SRC_W-1:0] r, input logic [SRC_W-1:0] c,
                           input logic [PIX_W-1:0] p, input logic [COORD_W-1:0] orow,
                           input logic [COORD_W-1:0] ocol);
    int gap;
    gap = draw_gap(feed_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    src_row <= r;
    src_col <= c;
    pixel_in <= p;
    out_row <= orow;
    out_col <= ocol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (k == KIND_LOAD) loaded[r * MAX_WIDTH + c] = 1'b1;
    else queries_sent++;
  endtask

  task automatic fill(input int unsigned r, input int unsigned c);
    if (!loaded[r * MAX_WIDTH + c])
      send_word(KIND_LOAD, SRC_W'(r), SRC_W'(c), PIX_W'($urandom),
                COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // load any neighbour not yet in the store, then ask for the pixel
  task automatic query_pixel(input logic [COORD_W-1:0] orow, input logic [COORD_W-1:0] ocol);
    int unsigned r0;
    int unsigned r1;
    int unsigned c0;
    int unsigned c1;
    r0 = axis_start(orow, eff_height);
    r1 = (r0 + 1 < eff_height) ? r0 + 1 : r0;
    c0 = axis_start(ocol, eff_width);
    c1 = (c0 + 1 < eff_width) ? c0 + 1 : c0;
    fill(r0, c0);
    fill(r0, c1);
    fill(r1, c0);
    fill(r1, c1);
    send_word(KIND_QUERY, SRC_W'($urandom), SRC_W'($urandom), PIX_W'($urandom), orow, ocol);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] w_word,
                              input logic [CFG_DATA_W-1:0] h_word,
                              input logic [CFG_DATA_W-1:0] s_word, input bit with_unused);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    int                    n;
    idx = '{REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT, REG_INVERSE_SCALE, REG_UNUSED};
    val = '{w_word, h_word, s_word, CFG_DATA_W'($urandom)};
    n = with_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    eff_width = dim_in_use(w_word[DIM_W-1:0], MAX_WIDTH);
    eff_height = dim_in_use(h_word[DIM_W-1:0], MAX_HEIGHT);
    eff_scale = 32'(s_word[SCALE_W-1:0]);
    settings_used++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : drain
    int gap;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      gap = draw_gap(drain_pace);
      if (drain_hold) begin
        gap = LONG_HOLD;
        drain_hold = 1'b0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
      if (range_error) clamped_seen++;
      @(negedge clk);
    end
  end

  initial begin : feed
    int                    phase_len;
    bit                    held;
    logic [CFG_DATA_W-1:0] s_word;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_LOAD;
    src_row = '0;
    src_col = '0;
    pixel_in = '0;
    out_row = '0;
    out_col = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SOURCE_WIDTH;
    cfg_data = '0;
    feed_pace = PACE_RANDOM;
    drain_pace = PACE_RANDOM;
    drain_hold = 1'b0;
    held = 1'b0;
    eff_width = MAX_WIDTH;
    eff_height = MAX_HEIGHT;
    eff_scale = RESET_INVERSE_SCALE;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset geometry, half-pixel steps: checkerboard corner gives truncation
    send_word(KIND_LOAD, 8'd0, 8'd0, 8'h00, 12'd0, 12'd0);
    send_word(KIND_LOAD, 8'd0, 8'd1, 8'hFF, 12'hFFF, 12'hFFF);
    send_word(KIND_LOAD, 8'd1, 8'd0, 8'hFF, 12'hFFF, 12'h000);
    send_word(KIND_LOAD, 8'd1, 8'd1, 8'h00, 12'h000, 12'hFFF);
    query_pixel(12'd0, 12'd0);
    query_pixel(12'd1, 12'd1);
    query_pixel(12'd1, 12'd0);
    send_word(KIND_LOAD, 8'd255, 8'd255, 8'hFF, 12'd0, 12'd0);
    query_pixel(12'd510, 12'd510);
    query_pixel(12'd509, 12'd511);
    query_pixel(12'hFFF, 12'hFFF);
    query_pixel(12'hFFF, 12'd3);
    settle();

    // single-pixel image
    program_regs(24'd1, 24'd1, 24'h010000, 1'b0);
    query_pixel(12'd0, 12'd0);
    query_pixel(12'd7, 12'hFFF);
    settle();

    // width zero, height above maximum, zero scale; junk register index
    program_regs(24'hFFFE00, 24'h0001FF, 24'd0, 1'b1);
    query_pixel(12'hFFF, 12'hFFF);
    query_pixel(12'd100, 12'd0);
    settle();

    // largest scale word
    program_regs(24'd256, 24'd256, 24'hFFFFFF, 1'b0);
    query_pixel(12'd0, 12'd0);
    query_pixel(12'd1, 12'd1);
    query_pixel(12'd2, 12'd0);
    settle();

    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 9))
        0:       s_word = CFG_DATA_W'($urandom);
        1:       s_word = 24'h010000;
        2, 3, 4: s_word = CFG_DATA_W'($urandom_range(24'h001000, 24'h010000));
        default: s_word = CFG_DATA_W'($urandom_range(24'h010000, 24'h040000));
      endcase
      program_regs({15'($urandom), DIM_W'(pick_dim())}, {15'($urandom), DIM_W'(pick_dim())},
                   s_word, $urandom_range(0, 3) == 0);
      feed_pace = pace_t'($urandom_range(0, 2));
      drain_pace = pace_t'($urandom_range(0, 2));
      if (!held) begin
        // back up the result side so the input stalls
        drain_hold = 1'b1;
        feed_pace = PACE_FULL;
        held = 1'b1;
      end
      phase_len = $urandom_range(30, 90);
      for (int i = 0; i < phase_len && words_sent < WORD_TARGET; i++) begin
        if ($urandom_range(0, 9) < 7)
          query_pixel(pick_coord(eff_height), pick_coord(eff_width));
        else
          send_word(KIND_LOAD, SRC_W'($urandom), SRC_W'($urandom), PIX_W'($urandom),
                    COORD_W'($urandom), COORD_W'($urandom));
      end
      settle();
    end

    $display("Scaler run: %0d words (%0d queries) over %0d register settings",
             words_sent, queries_sent, settings_used);
    $display("Results checked: %0d, clamped coordinates flagged: %0d",
             results_taken, clamped_seen);
    if (mismatches == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
